@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the alignment RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lalw_pkg.sv @@
// ----------------------------------------------------------------------------
// lalw_pkg
// Types, widths and codes of the local alignment wavefront.
// ----------------------------------------------------------------------------
package lalw_pkg;

  localparam int QUERY_LEN  = 32;
  localparam int MAX_DB_LEN = 65536;

  localparam int SYM_W     = 8;
  localparam int POS_W     = 5;
  localparam int ROW_W     = 16;
  localparam int DIRS_W    = 64;
  localparam int IDX_W     = 21;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int DIR_W     = 2;
  localparam int SCORE_W   = 15;
  localparam int SUM_W     = SCORE_W + 2;
  localparam int SEEN_W    = $clog2(MAX_DB_LEN + 1);
  localparam int CID_W     = $clog2(QUERY_LEN);

  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [DIR_W-1:0] DIR_CENTER = 2'd0;
  localparam logic [DIR_W-1:0] DIR_NORTH  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_NW     = 2'd2;
  localparam logic [DIR_W-1:0] DIR_WEST   = 2'd3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_STREAM = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_NORTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_WEST  = 2'd3;

  localparam logic signed [CFG_W-1:0] MATCH_RST     = 8'sd2;
  localparam logic signed [CFG_W-1:0] MISMATCH_RST  = -8'sd1;
  localparam logic signed [CFG_W-1:0] GAP_NORTH_RST = -8'sd1;
  localparam logic signed [CFG_W-1:0] GAP_WEST_RST  = -8'sd1;

  typedef struct packed {
    logic             opcode;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] query_position;
    logic             last_symbol;
  } in_item_t;

  typedef struct packed {
    logic              row_valid;
    logic [ROW_W-1:0]  row_number;
    logic [DIRS_W-1:0] direction_row;
    logic              is_final;
    logic [IDX_W-1:0]  best_index;
  } out_item_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] match;
    logic signed [CFG_W-1:0] mismatch;
    logic signed [CFG_W-1:0] gap_north;
    logic signed [CFG_W-1:0] gap_west;
  } score_cfg_t;

  typedef struct packed {
    logic             load;
    logic             shift;
    logic             compute;
    logic             clear;
    logic             scan;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] diag_base;
  } cell_ctrl_t;

  function automatic logic signed [SUM_W-1:0] sext_cfg(input logic signed [CFG_W-1:0] v);
    return {{(SUM_W - CFG_W){v[CFG_W-1]}}, v};
  endfunction

endpackage

@@ rtl/core/local_alignment_wavefront.sv @@
// ----------------------------------------------------------------------------
// local_alignment_wavefront
// Local alignment on an anti-diagonal wavefront: a row of QUERY_LEN cells,
// one anti-diagonal per database symbol, best index search at the end.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------
//  in      | in_valid / in_ready   | in_data  (opcode, symbol, pos, last)
//  out     | out_valid / out_ready | out_data (row, directions, best)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Query load and plain database symbol: each taken as a single item; the whole
//  diagonal of a database symbol is computed across the cell row on acceptance.
//  Last symbol: the per-cell bests shift down the cell chain into a single
//  compare at cell 0 during the best search.
//  Reset: synchronous; scores to defaults, alignment state cleared, query
//  store kept undefined until loaded.
//  in_ready drops during the best search and while both result slots hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module local_alignment_wavefront (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lalw_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lalw_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lalw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lalw_pkg::CFG_W-1:0]        cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam int QL = lalw_pkg::QUERY_LEN;

  lalw_pkg::score_cfg_t             scores;
  lalw_pkg::cell_ctrl_t             ctrl;
  lalw_pkg::out_item_t              push_item;

  logic                             state;
  logic [lalw_pkg::CID_W-1:0]       scan_cnt;
  logic [lalw_pkg::SEEN_W-1:0]      seen;
  logic [lalw_pkg::SEEN_W-1:0]      seen_inc;
  logic [lalw_pkg::SEEN_W-1:0]      k;
  logic [lalw_pkg::IDX_W-1:0]       base;
  logic                             step_valid;
  logic                             in_fire;
  logic                             stream_fire;
  logic                             load_fire;
  logic                             scan_done;
  logic                             push;
  logic                             has_space;

  logic [lalw_pkg::SCORE_W-1:0]     run_best;
  logic [lalw_pkg::SCORE_W-1:0]     run_best_next;
  logic [lalw_pkg::IDX_W-1:0]       run_idx;
  logic [lalw_pkg::IDX_W-1:0]       run_idx_next;

  logic                             pend_valid;
  logic [lalw_pkg::ROW_W-1:0]       pend_num;
  logic [lalw_pkg::DIRS_W-1:0]      pend_dirs;
  logic [lalw_pkg::DIRS_W-1:0]      dirs;

  logic [lalw_pkg::SYM_W-1:0]       win_c     [QL];
  logic [lalw_pkg::SCORE_W-1:0]     prev_c    [QL];
  logic [lalw_pkg::SCORE_W-1:0]     prev2_c   [QL];
  logic [lalw_pkg::SCORE_W-1:0]     best_c    [QL];
  logic [lalw_pkg::IDX_W-1:0]       idx_c     [QL];
  logic [lalw_pkg::DIR_W-1:0]       dir_c     [QL];
  logic [lalw_pkg::SYM_W-1:0]       win_nb    [QL];
  logic [lalw_pkg::SCORE_W-1:0]     prev_nb   [QL];
  logic [lalw_pkg::SCORE_W-1:0]     prev2_nb  [QL];
  logic [lalw_pkg::SCORE_W-1:0]     best_nb   [QL];
  logic [lalw_pkg::IDX_W-1:0]       idx_nb    [QL];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scores.match     <= lalw_pkg::MATCH_RST;
      scores.mismatch  <= lalw_pkg::MISMATCH_RST;
      scores.gap_north <= lalw_pkg::GAP_NORTH_RST;
      scores.gap_west  <= lalw_pkg::GAP_WEST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lalw_pkg::REG_MATCH:     scores.match     <= cfg_data;
        lalw_pkg::REG_MISMATCH:  scores.mismatch  <= cfg_data;
        lalw_pkg::REG_GAP_NORTH: scores.gap_north <= cfg_data;
        lalw_pkg::REG_GAP_WEST:  scores.gap_west  <= cfg_data;
        default:                 scores           <= scores;
      endcase
    end
  end

  // input side
  assign in_ready    = (state == ST_IDLE) && has_space;
  assign in_fire     = in_valid && in_ready;
  assign stream_fire = in_fire && (in_data.opcode == lalw_pkg::OP_STREAM);
  assign load_fire   = in_fire && (in_data.opcode == lalw_pkg::OP_LOAD);

  assign seen_inc   = (seen < lalw_pkg::SEEN_W'(lalw_pkg::MAX_DB_LEN))
                    ? seen + lalw_pkg::SEEN_W'(1) : seen;
  assign step_valid = seen_inc >= lalw_pkg::SEEN_W'(QL);
  assign k          = seen_inc - lalw_pkg::SEEN_W'(QL);
  assign scan_done  = (state == ST_SCAN) && (scan_cnt == lalw_pkg::CID_W'(QL - 1));

  always_comb begin
    ctrl.load      = load_fire;
    ctrl.shift     = stream_fire;
    ctrl.compute   = stream_fire && step_valid;
    ctrl.clear     = stream_fire && in_data.last_symbol;
    ctrl.scan      = state == ST_SCAN;
    ctrl.symbol    = in_data.symbol;
    ctrl.pos       = in_data.query_position;
    ctrl.diag_base = base;
  end

  // cell row
  for (genvar g = 0; g < QL; g++) begin : g_cell
    if (g == QL - 1) begin : g_edge
      assign win_nb[g]   = in_data.symbol;
      assign prev_nb[g]  = '0;
      assign prev2_nb[g] = '0;
      assign best_nb[g]  = '0;
      assign idx_nb[g]   = '0;
    end else begin : g_inner
      assign win_nb[g]   = win_c[g+1];
      assign prev_nb[g]  = prev_c[g+1];
      assign prev2_nb[g] = prev2_c[g+1];
      assign best_nb[g]  = best_c[g+1];
      assign idx_nb[g]   = idx_c[g+1];
    end

    lalw_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_id     (lalw_pkg::CID_W'(g)),
      .ctrl        (ctrl),
      .scores      (scores),
      .win_in      (win_nb[g]),
      .prev_in     (prev_nb[g]),
      .prev2_in    (prev2_nb[g]),
      .best_in     (best_nb[g]),
      .best_idx_in (idx_nb[g]),
      .win         (win_c[g]),
      .prev        (prev_c[g]),
      .prev2       (prev2_c[g]),
      .best        (best_c[g]),
      .best_idx    (idx_c[g]),
      .dir         (dir_c[g])
    );
  end

  always_comb begin
    dirs = '0;
    for (int i = 0; i < QL; i++) begin
      dirs[lalw_pkg::DIR_W*i +: lalw_pkg::DIR_W] = dir_c[i];
    end
  end

  // best search: first strict maximum, cell 0 arrives first
  always_comb begin
    run_best_next = run_best;
    run_idx_next  = run_idx;
    if (best_c[0] > run_best) begin
      run_best_next = best_c[0];
      run_idx_next  = idx_c[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      seen     <= '0;
      base     <= '0;
      run_best <= '0;
      run_idx  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (stream_fire) begin
            if (in_data.last_symbol) begin
              seen     <= '0;
              base     <= '0;
              scan_cnt <= '0;
              run_best <= '0;
              run_idx  <= '0;
              state    <= ST_SCAN;
            end else begin
              seen <= seen_inc;
              if (step_valid && seen_inc < lalw_pkg::SEEN_W'(lalw_pkg::MAX_DB_LEN)) begin
                base <= base + lalw_pkg::IDX_W'(QL);
              end
            end
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + lalw_pkg::CID_W'(1);
          run_best <= run_best_next;
          run_idx  <= run_idx_next;
          if (scan_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // row fields of the last symbol wait here for the search
  always_ff @(posedge clk) begin
    if (stream_fire && in_data.last_symbol) begin
      pend_valid <= step_valid;
      pend_num   <= step_valid ? lalw_pkg::ROW_W'(k) : '0;
      pend_dirs  <= step_valid ? dirs : '0;
    end
  end

  assign push = (stream_fire && !in_data.last_symbol && step_valid) || scan_done;

  always_comb begin
    if (state == ST_SCAN) begin
      push_item.row_valid     = pend_valid;
      push_item.row_number    = pend_num;
      push_item.direction_row = pend_dirs;
      push_item.is_final      = 1'b1;
      push_item.best_index    = run_idx_next;
    end else begin
      push_item.row_valid     = 1'b1;
      push_item.row_number    = lalw_pkg::ROW_W'(k);
      push_item.direction_row = dirs;
      push_item.is_final      = 1'b0;
      push_item.best_index    = '0;
    end
  end

  lalw_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .has_space (has_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_IMPLIES(a_scan_blocks_input, clk, rst, state == ST_SCAN, !in_ready, "item taken during search")
  `ASSERT_NEXT(a_last_starts_scan, clk, rst, stream_fire && in_data.last_symbol, state == ST_SCAN, "last symbol did not start search")
  `ASSERT_NEXT(a_scan_drains_row, clk, rst, scan_done, best_c[0] == '0, "cell bests not drained after search")
  `ASSERT_IMPLIES(a_seen_bounded, clk, rst, 1'b1, seen <= lalw_pkg::SEEN_W'(lalw_pkg::MAX_DB_LEN), "symbol count past limit")

endmodule

@@ rtl/core/lalw_cell.sv @@
// ----------------------------------------------------------------------------
// lalw_cell
// One wavefront cell: query char, window symbol, two diagonal scores and
// the running best with its index. Talks to its upper neighbor only.
// ----------------------------------------------------------------------------
module lalw_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lalw_pkg::CID_W-1:0]    cell_id,
  input  lalw_pkg::cell_ctrl_t          ctrl,
  input  lalw_pkg::score_cfg_t          scores,
  input  logic [lalw_pkg::SYM_W-1:0]    win_in,
  input  logic [lalw_pkg::SCORE_W-1:0]  prev_in,
  input  logic [lalw_pkg::SCORE_W-1:0]  prev2_in,
  input  logic [lalw_pkg::SCORE_W-1:0]  best_in,
  input  logic [lalw_pkg::IDX_W-1:0]    best_idx_in,
  output logic [lalw_pkg::SYM_W-1:0]    win,
  output logic [lalw_pkg::SCORE_W-1:0]  prev,
  output logic [lalw_pkg::SCORE_W-1:0]  prev2,
  output logic [lalw_pkg::SCORE_W-1:0]  best,
  output logic [lalw_pkg::IDX_W-1:0]    best_idx,
  output logic [lalw_pkg::DIR_W-1:0]    dir
);

  logic [lalw_pkg::SYM_W-1:0]         qsym;
  logic [lalw_pkg::CID_W-1:0]         slot;
  logic [lalw_pkg::IDX_W-1:0]         offset;
  logic signed [lalw_pkg::SUM_W-1:0]  sub;
  logic signed [lalw_pkg::SUM_W-1:0]  north;
  logic signed [lalw_pkg::SUM_W-1:0]  nw;
  logic signed [lalw_pkg::SUM_W-1:0]  west;
  logic signed [lalw_pkg::SUM_W-1:0]  top;
  logic [lalw_pkg::SCORE_W-1:0]       score_new;

  // cell i pairs query[QUERY_LEN-1-i] with window[i]
  assign slot   = lalw_pkg::CID_W'(lalw_pkg::QUERY_LEN - 1) - cell_id;
  assign offset = lalw_pkg::IDX_W'(cell_id) * lalw_pkg::IDX_W'(lalw_pkg::QUERY_LEN)
                + lalw_pkg::IDX_W'(slot);

  always_comb begin
    sub   = (qsym == win_in) ? lalw_pkg::sext_cfg(scores.match)
                             : lalw_pkg::sext_cfg(scores.mismatch);
    north = $signed({2'b00, prev}) + lalw_pkg::sext_cfg(scores.gap_north);
    nw    = $signed({2'b00, prev2_in}) + sub;
    west  = $signed({2'b00, prev_in}) + lalw_pkg::sext_cfg(scores.gap_west);
    top   = north;
    dir   = lalw_pkg::DIR_NORTH;
    if (top < nw) begin
      top = nw;
      dir = lalw_pkg::DIR_NW;
    end
    if (top < west) begin
      top = west;
      dir = lalw_pkg::DIR_WEST;
    end
    if (top[lalw_pkg::SUM_W-1] || top == '0) begin
      top = '0;
      dir = lalw_pkg::DIR_CENTER;
    end
    if (top > $signed({2'b00, lalw_pkg::SCORE_MAX})) begin
      score_new = lalw_pkg::SCORE_MAX;
    end else begin
      score_new = top[lalw_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.pos == lalw_pkg::POS_W'(slot)) begin
      qsym <= ctrl.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      prev     <= '0;
      prev2    <= '0;
      best     <= '0;
      best_idx <= '0;
    end else begin
      if (ctrl.clear) begin
        win   <= '0;
        prev  <= '0;
        prev2 <= '0;
      end else begin
        if (ctrl.shift) begin
          win <= win_in;
        end
        if (ctrl.compute) begin
          prev  <= score_new;
          prev2 <= prev;
        end
      end
      // bests drain toward cell 0 during the search, zeros follow behind
      if (ctrl.scan) begin
        best     <= best_in;
        best_idx <= best_idx_in;
      end else if (ctrl.compute && score_new > best) begin
        best     <= score_new;
        best_idx <= ctrl.diag_base + offset;
      end
    end
  end

endmodule

@@ rtl/core/lalw_out_buf.sv @@
// ----------------------------------------------------------------------------
// lalw_out_buf
// Two-entry result queue between the cell row and the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lalw_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lalw_pkg::out_item_t  push_item,
  output logic                 has_space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lalw_pkg::out_item_t  out_data
);

  lalw_pkg::out_item_t                entry [lalw_pkg::OBUF_DEPTH];
  logic [lalw_pkg::OBUF_PTR_W-1:0]    wr_ptr;
  logic [lalw_pkg::OBUF_PTR_W-1:0]    rd_ptr;
  logic [lalw_pkg::OBUF_CNT_W-1:0]    count;
  logic                               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign has_space = count != lalw_pkg::OBUF_CNT_W'(lalw_pkg::OBUF_DEPTH);
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lalw_pkg::OBUF_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lalw_pkg::OBUF_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + lalw_pkg::OBUF_CNT_W'(1);
        2'b01:   count <= count - lalw_pkg::OBUF_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, has_space, "result queue overflow")

endmodule

@@ tb/sv/tb_local_alignment_wavefront.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_alignment_wavefront
// Self-checking bench for the alignment wavefront. Checks direction rows and
// best indices against a behavioral copy of the cell row. Stimulus is a
// directed table followed by random query loads and database sequences under
// several score settings.
// ----------------------------------------------------------------------------
module tb_local_alignment_wavefront;
  import lalw_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = QUERY_LEN + 8;
  localparam int SCORE_CAP     = 32767;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic      fixed;
    out_item_t fixed_out;
  } item_tag_t;

  typedef struct packed {
    in_item_t  item;
    logic [7:0] reps;
    logic      fixed;
    out_item_t fixed_out;
  } stim_row_t;

  localparam out_item_t FINAL_ONLY = '{row_valid: 1'b0, row_number: '0, direction_row: '0,
                                       is_final: 1'b1, best_index: '0};

  localparam stim_row_t DIRECTED [15] = '{
    '{'{OP_STREAM, 8'h00, 5'd0,  1'b1}, 8'd1,  1'b1, FINAL_ONLY},
    '{'{OP_STREAM, 8'hFF, 5'd31, 1'b0}, 8'd1,  1'b0, '0},
    '{'{OP_STREAM, 8'h5A, 5'd0,  1'b1}, 8'd1,  1'b1, FINAL_ONLY},
    '{'{OP_LOAD,   8'hFF, 5'd0,  1'b1}, 8'd1,  1'b0, '0},
    '{'{OP_LOAD,   8'h00, 5'd31, 1'b0}, 8'd1,  1'b0, '0},
    '{'{OP_LOAD,   8'hA5, 5'd15, 1'b0}, 8'd1,  1'b0, '0},
    '{'{OP_LOAD,   8'h5A, 5'd16, 1'b1}, 8'd1,  1'b0, '0},
    '{'{OP_STREAM, 8'h00, 5'd31, 1'b0}, 8'd31, 1'b0, '0},
    '{'{OP_STREAM, 8'hFF, 5'd0,  1'b0}, 8'd1,  1'b0, '0},
    '{'{OP_STREAM, 8'hA5, 5'd7,  1'b0}, 8'd4,  1'b0, '0},
    '{'{OP_STREAM, 8'h5A, 5'd24, 1'b1}, 8'd1,  1'b0, '0},
    '{'{OP_STREAM, 8'hFF, 5'd0,  1'b0}, 8'd31, 1'b0, '0},
    '{'{OP_STREAM, 8'h00, 5'd31, 1'b1}, 8'd1,  1'b0, '0},
    '{'{OP_STREAM, 8'h41, 5'd3,  1'b0}, 8'd40, 1'b0, '0},
    '{'{OP_STREAM, 8'h41, 5'd9,  1'b1}, 8'd1,  1'b0, '0}
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 72;
  int unsigned items_sent    = 0;
  int unsigned fault_count   = 0;
  int unsigned cycle_count   = 0;

  item_tag_t item_tags [$];
  out_item_t expected_rows [$];

  // behavioral state of the cell row
  logic [SYM_W-1:0] query_mem [QUERY_LEN];
  logic [SYM_W-1:0] window [QUERY_LEN];
  int               diag_prev [QUERY_LEN+1];
  int               diag_prev2 [QUERY_LEN+1];
  int               cell_top [QUERY_LEN];
  logic [IDX_W-1:0] cell_top_idx [QUERY_LEN];
  int unsigned      db_seen;
  int               sc_match, sc_mismatch, sc_gap_n, sc_gap_w;

  local_alignment_wavefront dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_alignment();
    int i;
    for (i = 0; i < QUERY_LEN; i++) begin
      window[i]       = '0;
      cell_top[i]     = 0;
      cell_top_idx[i] = '0;
    end
    for (i = 0; i <= QUERY_LEN; i++) begin
      diag_prev[i]  = 0;
      diag_prev2[i] = 0;
    end
    db_seen = 0;
  endfunction

  function automatic bit wavefront_step(input in_item_t it, output out_item_t res);
    int               next_diag [QUERY_LEN+1];
    int               north, diag, west, pick, top;
    int               i, j;
    int unsigned      k;
    logic [DIR_W-1:0] dir;
    logic [IDX_W-1:0] top_idx;
    res = '0;
    if (it.opcode == OP_LOAD) begin
      if (it.query_position < QUERY_LEN) query_mem[it.query_position] = it.symbol;
      return 1'b0;
    end
    if (db_seen < MAX_DB_LEN) db_seen++;
    for (i = 0; i < QUERY_LEN - 1; i++) window[i] = window[i+1];
    window[QUERY_LEN-1] = it.symbol;
    if (db_seen >= QUERY_LEN) begin
      k = db_seen - QUERY_LEN;
      for (i = 0; i < QUERY_LEN; i++) begin
        j     = QUERY_LEN - 1 - i;
        north = diag_prev[i] + sc_gap_n;
        diag  = diag_prev2[i+1] + ((query_mem[j] == window[i]) ? sc_match : sc_mismatch);
        west  = diag_prev[i+1] + sc_gap_w;
        pick  = north;
        dir   = DIR_NORTH;
        if (diag > pick) begin
          pick = diag;
          dir  = DIR_NW;
        end
        if (west > pick) begin
          pick = west;
          dir  = DIR_WEST;
        end
        if (pick <= 0) begin
          pick = 0;
          dir  = DIR_CENTER;
        end
        if (pick > SCORE_CAP) pick = SCORE_CAP;
        next_diag[i] = pick;
        res.direction_row[DIR_W*i +: DIR_W] = dir;
        if (pick > cell_top[i]) begin
          cell_top[i]     = pick;
          cell_top_idx[i] = IDX_W'((i + k) * QUERY_LEN + j);
        end
      end
      next_diag[QUERY_LEN] = 0;
      diag_prev2 = diag_prev;
      diag_prev  = next_diag;
      res.row_valid  = 1'b1;
      res.row_number = k[ROW_W-1:0];
    end
    if (!res.row_valid && !it.last_symbol) return 1'b0;
    if (it.last_symbol) begin
      top     = 0;
      top_idx = '0;
      for (i = 0; i < QUERY_LEN; i++) begin
        if (cell_top[i] > top) begin
          top     = cell_top[i];
          top_idx = cell_top_idx[i];
        end
      end
      res.is_final   = 1'b1;
      res.best_index = top_idx;
      clear_alignment();
    end
    return 1'b1;
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_local_alignment_wavefront: done, errors");
      $finish;
    end
  end

  // scoreboard: prediction on accepted items, comparison on accepted results
  always @(posedge clk) begin : scoreboard
    item_tag_t tag;
    out_item_t calc;
    out_item_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MATCH:     sc_match    = int'($signed(cfg_data));
          REG_MISMATCH:  sc_mismatch = int'($signed(cfg_data));
          REG_GAP_NORTH: sc_gap_n    = int'($signed(cfg_data));
          REG_GAP_WEST:  sc_gap_w    = int'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        tag = item_tags.pop_front();
        if (wavefront_step(in_data, calc))
          expected_rows.push_back(tag.fixed ? tag.fixed_out : calc);
      end
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected result item: %h", out_data);
          fault_count++;
        end else begin
          want = expected_rows.pop_front();
          if (out_data.row_valid !== want.row_valid) begin
            $error("row_valid: expected %0d, got %0d", want.row_valid, out_data.row_valid);
            fault_count++;
          end
          if (out_data.row_number !== want.row_number) begin
            $error("row_number: expected %0d, got %0d", want.row_number, out_data.row_number);
            fault_count++;
          end
          if (out_data.direction_row !== want.direction_row) begin
            $error("direction_row: expected %h, got %h", want.direction_row,
                   out_data.direction_row);
            fault_count++;
          end
          if (out_data.is_final !== want.is_final) begin
            $error("is_final: expected %0d, got %0d", want.is_final, out_data.is_final);
            fault_count++;
          end
          if (out_data.best_index !== want.best_index) begin
            $error("best_index: expected %0d, got %0d", want.best_index, out_data.best_index);
            fault_count++;
          end
        end
      end
    end
  end

  function automatic logic [SYM_W-1:0] pick_symbol();
    if ($urandom_range(0, 7) == 0) return SYM_W'($urandom_range(0, 255));
    return SYM_W'(8'h41 + $urandom_range(0, 3));
  endfunction

  task automatic send_item(input in_item_t it, input logic fixed, input out_item_t fixed_out);
    item_tag_t tag;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    tag.fixed     = fixed;
    tag.fixed_out = fixed_out;
    item_tags.push_back(tag);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_stream(input logic [SYM_W-1:0] sym, input logic last);
    in_item_t it;
    it.opcode         = OP_STREAM;
    it.symbol         = sym;
    it.query_position = POS_W'($urandom_range(0, 31));
    it.last_symbol    = last;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_load(input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym);
    in_item_t it;
    it.opcode         = OP_LOAD;
    it.symbol         = sym;
    it.query_position = pos;
    it.last_symbol    = 1'($urandom_range(0, 1));
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // drains results and lets the block go idle before writing the scores
  task automatic set_scores(input score_cfg_t s);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(REG_MATCH, s.match);
    put_reg(REG_MISMATCH, s.mismatch);
    put_reg(REG_GAP_NORTH, s.gap_north);
    put_reg(REG_GAP_WEST, s.gap_west);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned start, len, s;
    logic        ends;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(0, 7) == 0) drain_results();
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 4)) send_load(POS_W'($urandom_range(0, 31)), pick_symbol());
      // mostly full sequences, some ending before the window fills
      len  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, QUERY_LEN - 1)
                                         : $urandom_range(QUERY_LEN, QUERY_LEN + 12);
      ends = ($urandom_range(0, 9) != 0);
      for (s = 1; s <= len; s++) begin
        if ($urandom_range(0, 19) == 0)
          send_load(POS_W'($urandom_range(0, 31)), pick_symbol());
        send_stream(pick_symbol(), ends && (s == len));
      end
    end
  endtask

  initial begin : stimulus
    score_cfg_t phase_scores [6];
    int         r, p;
    sc_match    = MATCH_RST;
    sc_mismatch = MISMATCH_RST;
    sc_gap_n    = GAP_NORTH_RST;
    sc_gap_w    = GAP_WEST_RST;
    for (r = 0; r < QUERY_LEN; r++) query_mem[r] = '0;
    clear_alignment();

    phase_scores[0] = '{match: 8'sd2,    mismatch: -8'sd1,   gap_north: -8'sd1,
                        gap_west: -8'sd1};
    phase_scores[1] = '{match: 8'sd127,  mismatch: -8'sd128, gap_north: -8'sd128,
                        gap_west: -8'sd128};
    phase_scores[2] = '{match: -8'sd128, mismatch: -8'sd128, gap_north: -8'sd128,
                        gap_west: -8'sd128};
    phase_scores[3] = '{match: 8'sd127,  mismatch: 8'sd127,  gap_north: 8'sd127,
                        gap_west: 8'sd127};
    phase_scores[4] = '{match: CFG_W'($urandom_range(0, 255)),
                        mismatch: CFG_W'($urandom_range(0, 255)),
                        gap_north: CFG_W'($urandom_range(0, 255)),
                        gap_west: CFG_W'($urandom_range(0, 255))};
    phase_scores[5] = '{match: 8'sd5,    mismatch: -8'sd3,   gap_north: -8'sd2,
                        gap_west: -8'sd4};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < QUERY_LEN; r++) send_load(POS_W'(r), pick_symbol());
    for (r = 0; r < $size(DIRECTED); r++)
      repeat (DIRECTED[r].reps)
        send_item(DIRECTED[r].item, DIRECTED[r].fixed, DIRECTED[r].fixed_out);

    for (p = 0; p < 6; p++) begin
      set_scores(phase_scores[p]);
      if (p < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 72;
      end else if (p < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(PHASE_ITEMS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_rows.size() == 0)
      $display("tb_local_alignment_wavefront: done, clean");
    else
      $display("tb_local_alignment_wavefront: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/lalw_pkg.sv
rtl/core/lalw_cell.sv
rtl/core/lalw_out_buf.sv
rtl/core/local_alignment_wavefront.sv
tb/sv/tb_local_alignment_wavefront.sv
